// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the strict-priority fair queue scheduler.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_FLOWS   = 256;

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int DW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(NUM_FLOWS);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_ENQ      = 3'd0;
  localparam logic [2:0] ST_DROP_RNG = 3'd1;
  localparam logic [2:0] ST_DROP_FUL = 3'd2;
  localparam logic [2:0] ST_DEQ      = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  flow_id;
    logic [7:0]  flow_weight;
    logic [15:0] packet_handle;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         queue_index;
    logic [15:0]        out_handle;
    logic signed [31:0] out_rank;
  } out_beat_t;

endpackage

// ===== hw/rtl/sp_pifo_fair_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// sp_pifo_fair_queue_scheduler
// Strict-priority FIFO scheduler approximating a push-in first-out queue.
// ----------------------------------------------------------------------------
// Usage: drive in_beat and pulse start while busy is low; one command is
// taken per accepted beat. Each command yields exactly one result beat on
// out_beat, marked by a one-cycle out_valid pulse; the receiver cannot stall.
// Enqueue: flow table read (S_FRD), rank (S_RANK), bound scan (S_SCAN) over
// queues NUM_QUEUES-1 down to 0, on push-down the bound update (S_PDN), push
// (S_PUSH), result (S_OUT); a rank range drop goes from S_RANK to S_OUT.
// Dequeue: scan (S_DSCN) from queue 0 up to the first nonempty one, packet read
// (S_DRD, S_DOUT), result (S_OUT); an empty dequeue scans every queue first.
// busy is high from accept until the result cycle. The scan uses one shared
// signed comparator, one queue per cycle; the flow table and the packet store
// are single-port memories with registered reads.
// After reset the block clears the flow table, one entry per cycle, with busy held
// high; configuration writes are taken throughout. rank_range resets to 4096.
// ----------------------------------------------------------------------------
module sp_pifo_fair_queue_scheduler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output spq_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FRD  = 4'd2;
  localparam logic [3:0] S_RANK = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_PUSH = 4'd5;
  localparam logic [3:0] S_PDN  = 4'd6;
  localparam logic [3:0] S_DSCN = 4'd7;
  localparam logic [3:0] S_DRD  = 4'd8;
  localparam logic [3:0] S_DOUT = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic [15:0] range_r;
  logic signed [31:0] round_r;
  logic signed [31:0] bound_r [spq_pkg::NUM_QUEUES];
  logic [spq_pkg::DW-1:0] head_r [spq_pkg::NUM_QUEUES];
  logic [spq_pkg::DW-1:0] tail_r [spq_pkg::NUM_QUEUES];
  logic [spq_pkg::CW-1:0] cnt_r [spq_pkg::NUM_QUEUES];

  logic [31:0] flow_mem [spq_pkg::NUM_FLOWS];
  logic [31:0] flow_rd_r;
  logic [47:0] pkt_mem [spq_pkg::NUM_QUEUES * spq_pkg::QUEUE_DEPTH];
  logic [47:0] pkt_rd_r;

  logic [spq_pkg::FW-1:0] clr_r;
  spq_pkg::in_beat_t cmd_r;
  logic [spq_pkg::QW-1:0] q_r;
  logic signed [31:0] rank_r;
  spq_pkg::out_beat_t res_r;
  logic out_valid_r;

  logic flow_we;
  logic [spq_pkg::FW-1:0] flow_addr;
  logic [31:0] flow_wd;
  logic pkt_we;
  logic [spq_pkg::QW+spq_pkg::DW-1:0] pkt_addr;

  logic signed [31:0] last_s;
  logic signed [31:0] rank_c;
  logic signed [32:0] rank_gap;
  logic ge_cur;
  logic signed [31:0] cost;
  logic full_q;

  assign last_s   = $signed(flow_rd_r);
  assign rank_c   = (last_s > round_r) ? last_s : round_r;
  assign rank_gap = {rank_c[31], rank_c} - {round_r[31], round_r};
  assign ge_cur   = rank_r >= bound_r[q_r];
  assign cost     = bound_r[0] - rank_r;
  assign full_q   = cnt_r[q_r] >= spq_pkg::CW'(spq_pkg::QUEUE_DEPTH);

  always_comb begin
    flow_we   = 1'b0;
    flow_addr = cmd_r.flow_id[spq_pkg::FW-1:0];
    flow_wd   = 32'(rank_c + $signed({24'd0, cmd_r.flow_weight}));
    if (state_r == S_CLR) begin
      flow_we   = 1'b1;
      flow_addr = clr_r;
      flow_wd   = '0;
    end else if (state_r == S_RANK) begin
      flow_we = (rank_gap <= $signed({17'd0, range_r}));
    end
    pkt_we   = (state_r == S_PUSH) && !full_q;
    pkt_addr = (state_r == S_PUSH) ? {q_r, tail_r[q_r]} : {q_r, head_r[q_r]};
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_addr] <= flow_wd;
    end
    flow_rd_r <= flow_mem[flow_addr];
    if (pkt_we) begin
      pkt_mem[pkt_addr] <= {cmd_r.packet_handle, rank_r};
    end
    if (state_r == S_DSCN) begin
      pkt_rd_r <= pkt_mem[pkt_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == spq_pkg::FW'(spq_pkg::NUM_FLOWS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (start) begin
        state_nxt = (in_beat.func == spq_pkg::FUNC_DEQ) ? S_DSCN : S_FRD;
      end
      S_FRD:  state_nxt = S_RANK;
      S_RANK: begin
        state_nxt = (rank_gap > $signed({17'd0, range_r})) ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        if (ge_cur) state_nxt = S_PUSH;
        else if (q_r == '0) state_nxt = S_PDN;
      end
      S_PUSH: state_nxt = S_OUT;
      S_PDN:  state_nxt = S_PUSH;
      S_DSCN: begin
        if (cnt_r[q_r] != '0) state_nxt = S_DRD;
        else if (q_r == spq_pkg::QW'(spq_pkg::NUM_QUEUES - 1)) state_nxt = S_OUT;
      end
      S_DRD:  state_nxt = S_DOUT;
      S_DOUT: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      q_r         <= '0;
      range_r     <= 16'd4096;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < spq_pkg::NUM_QUEUES; i++) begin
        bound_r[i] <= '0;
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        cnt_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_OUT);
      if (cfg_we) range_r <= cfg_wdata;
      case (state_r)
        S_CLR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (start) begin
          cmd_r <= in_beat;
          q_r   <= (in_beat.func == spq_pkg::FUNC_DEQ) ? '0 :
                   spq_pkg::QW'(spq_pkg::NUM_QUEUES - 1);
        end
        S_FRD: ;
        S_RANK: begin
          res_r.out_handle  <= cmd_r.packet_handle;
          res_r.out_rank    <= rank_c;
          res_r.queue_index <= '0;
          res_r.status      <= spq_pkg::ST_DROP_RNG;
        end
        S_SCAN: if (!ge_cur && q_r != '0) q_r <= q_r - 1'b1;
        S_PDN: ;
        S_PUSH: begin
          res_r.queue_index <= 3'(q_r);
          if (full_q) begin
            res_r.status <= spq_pkg::ST_DROP_FUL;
          end else begin
            res_r.status <= spq_pkg::ST_ENQ;
            tail_r[q_r]  <= (tail_r[q_r] == spq_pkg::DW'(spq_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : tail_r[q_r] + 1'b1;
            cnt_r[q_r]   <= cnt_r[q_r] + 1'b1;
            if (!(q_r == '0 && !ge_cur)) bound_r[q_r] <= rank_r;
          end
        end
        S_DSCN: begin
          if (cnt_r[q_r] != '0) begin
            head_r[q_r] <= (head_r[q_r] == spq_pkg::DW'(spq_pkg::QUEUE_DEPTH - 1)) ?
                           '0 : head_r[q_r] + 1'b1;
            cnt_r[q_r]  <= cnt_r[q_r] - 1'b1;
          end else if (q_r == spq_pkg::QW'(spq_pkg::NUM_QUEUES - 1)) begin
            res_r <= '{status: spq_pkg::ST_EMPTY, queue_index: '0,
                       out_handle: '0, out_rank: '0};
          end else begin
            q_r <= q_r + 1'b1;
          end
        end
        S_DRD: ;
        S_DOUT: begin
          round_r           <= $signed(pkt_rd_r[31:0]);
          res_r.status      <= spq_pkg::ST_DEQ;
          res_r.queue_index <= 3'(q_r);
          res_r.out_handle  <= pkt_rd_r[47:32];
          res_r.out_rank    <= $signed(pkt_rd_r[31:0]);
        end
        default: ;
      endcase
      if (state_r == S_PDN && !full_q) begin
        bound_r[0] <= rank_r;
        for (int j = 1; j < spq_pkg::NUM_QUEUES; j++) begin
          bound_r[j] <= bound_r[j] - cost;
        end
      end
    end
  end

  // hold rank: max of flow finish round and current round, once the read lands
  always_ff @(posedge clk) begin
    if (state_r == S_RANK) begin
      rank_r <= rank_c;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = res_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_OUT))
    else $error("result beat without output state");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[q_r] <= spq_pkg::CW'(spq_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !flow_we && !pkt_we)
    else $error("memory write while idle");
  a_push_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH) |=> (state_r == S_OUT))
    else $error("push not followed by result");

endmodule

// ===== test/sp_pifo_fair_queue_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// sp_pifo_fair_queue_scheduler_test
// Self-checking bench for the strict-priority fair queue scheduler. Directed
// commands, then random bursts, are driven; a scoreboard predicts each result
// from its own model of rounds, bounds, flow finish rounds and queue contents.
// ----------------------------------------------------------------------------
class sched_scoreboard;
  logic [15:0]        range_q;
  logic [31:0]        round_q;
  logic [31:0]        bound_q [spq_pkg::NUM_QUEUES];
  logic [31:0]        finish_q [spq_pkg::NUM_FLOWS];
  logic [47:0]        queue_q [spq_pkg::NUM_QUEUES][$];
  spq_pkg::out_beat_t pending_q [$];
  int                 errors;
  int                 checked;
  int                 drops;
  int                 pushdowns;
  int                 fulls;
  int                 empties;

  function new();
    range_q = 16'd4096;
    round_q = '0;
    foreach (bound_q[i]) bound_q[i] = '0;
    foreach (finish_q[i]) finish_q[i] = '0;
    errors = 0;
    checked = 0;
    drops = 0;
    pushdowns = 0;
    fulls = 0;
    empties = 0;
  endfunction

  function void set_range(logic [15:0] v);
    range_q = v;
  endfunction

  function void note_command(spq_pkg::in_beat_t b);
    spq_pkg::out_beat_t r;
    logic [31:0]        rank;
    logic [31:0]        cost;
    longint             gap;
    int                 q;
    bit                 done;
    r = '0;
    if (b.func == spq_pkg::FUNC_DEQ) begin
      r.status = spq_pkg::ST_EMPTY;
      for (int i = 0; i < spq_pkg::NUM_QUEUES; i++) begin
        if (queue_q[i].size() != 0 && r.status == spq_pkg::ST_EMPTY) begin
          r.status = spq_pkg::ST_DEQ;
          r.queue_index = i[2:0];
          {r.out_handle, r.out_rank} = queue_q[i].pop_front();
          round_q = r.out_rank;
        end
      end
      if (r.status == spq_pkg::ST_EMPTY) empties++;
    end else begin
      rank = ($signed(finish_q[b.flow_id]) > $signed(round_q)) ? finish_q[b.flow_id] : round_q;
      gap = longint'($signed(rank)) - longint'($signed(round_q));
      r.out_handle = b.packet_handle;
      r.out_rank = rank;
      if (gap > longint'(range_q)) begin
        r.status = spq_pkg::ST_DROP_RNG;
        drops++;
      end else begin
        finish_q[b.flow_id] = rank + {24'd0, b.flow_weight};
        done = 0;
        q = 0;
        for (int i = spq_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
          if (!done && $signed(rank) >= $signed(bound_q[i])) begin
            done = 1;
            q = i;
          end
        end
        r.queue_index = q[2:0];
        if (queue_q[q].size() >= spq_pkg::QUEUE_DEPTH) begin
          r.status = spq_pkg::ST_DROP_FUL;
          fulls++;
        end else begin
          r.status = spq_pkg::ST_ENQ;
          queue_q[q].insert(queue_q[q].size(), {b.packet_handle, rank});
          if (done) begin
            bound_q[q] = rank;
          end else begin
            pushdowns++;
            cost = bound_q[0] - rank;
            bound_q[0] = rank;
            for (int j = 1; j < spq_pkg::NUM_QUEUES; j++) bound_q[j] -= cost;
          end
        end
      end
    end
    pending_q.insert(pending_q.size(), r);
  endfunction

  task check_result(spq_pkg::out_beat_t got);
    spq_pkg::out_beat_t want;
    if (pending_q.size() == 0) begin
      report("unexpected result", 64'd0, 64'(got));
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (got.status !== want.status)
      report("status", 64'(want.status), 64'(got.status));
    if (got.queue_index !== want.queue_index)
      report("queue_index", 64'(want.queue_index), 64'(got.queue_index));
    if (got.out_handle !== want.out_handle)
      report("out_handle", 64'(want.out_handle), 64'(got.out_handle));
    if (got.out_rank !== want.out_rank)
      report("out_rank", 64'(unsigned'(want.out_rank)), 64'(unsigned'(got.out_rank)));
  endtask

  task report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 40)
      $display("mismatch %0s: expected %0h got %0h (result %0d)", what, want, got, checked);
  endtask
endclass

module sp_pifo_fair_queue_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  spq_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  spq_pkg::out_beat_t out_beat;
  logic               cfg_we = 1'b0;
  logic [15:0]        cfg_wdata = '0;

  sched_scoreboard board;
  int idle_cycles;
  int sent;

  sp_pifo_fair_queue_scheduler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) board.note_command(in_beat);
      if (out_valid) board.check_result(out_beat);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(spq_pkg::in_beat_t b);
    start <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_enq(int flow, int weight, int handle);
    spq_pkg::in_beat_t b;
    b.func = spq_pkg::FUNC_ENQ;
    b.flow_id = flow[7:0];
    b.flow_weight = weight[7:0];
    b.packet_handle = handle[15:0];
    send(b);
  endtask

  task automatic send_deq();
    spq_pkg::in_beat_t b;
    b.func = spq_pkg::FUNC_DEQ;
    b.flow_id = 8'($urandom);
    b.flow_weight = 8'($urandom);
    b.packet_handle = 16'($urandom);
    send(b);
  endtask

  task automatic drain_then_config(logic [15:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_range(v);
  endtask

  task automatic random_phase(int count, int deq_pct, int flows, int max_w);
    int burst;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && n < count; k++) begin
        if ($urandom_range(0, 99) < deq_pct) send_deq();
        else send_enq($urandom_range(0, flows - 1), $urandom_range(0, max_w),
                      $urandom_range(0, 65535));
        n++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  initial begin
    board = new();
    idle_cycles = 0;
    sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_deq();
    send_enq(0, 255, 16'hFFFF);
    send_enq(255, 0, 16'h0000);
    send_enq(0, 255, 16'h1234);
    send_enq(0, 255, 16'h5678);
    send_enq(7, 1, 16'hA5A5);
    send_deq();
    send_deq();
    send_enq(0, 0, 16'h0F0F);
    send_deq();
    send_deq();
    send_deq();
    send_deq();
    send_deq();
    drain_then_config(16'd0);
    send_enq(0, 10, 16'h0001);
    send_enq(0, 10, 16'h0002);
    send_enq(9, 0, 16'h0003);
    send_deq();
    send_deq();
    send_deq();
    drain_then_config(16'hFFFF);
    for (int i = 0; i < 70; i++) send_enq(3, 0, i);
    for (int i = 0; i < 72; i++) send_deq();

    random_phase(350, 45, 256, 255);
    drain_then_config(16'd300);
    random_phase(250, 40, 16, 40);
    drain_then_config(16'd1);
    random_phase(150, 50, 8, 3);
    drain_then_config(16'd4096);
    random_phase(200, 20, 32, 255);
    random_phase(100, 90, 32, 255);

    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("covered %0d commands, %0d results: %0d range drops, %0d full drops,",
             sent, board.checked, board.drops, board.fulls);
    $display("%0d push-downs, %0d empty dequeues, five range settings",
             board.pushdowns, board.empties);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/sp_pifo_fair_queue_scheduler.sv
test/sp_pifo_fair_queue_scheduler_test.sv
